// ===== hdl/rcat_pkg.sv =====
// Shared types and constants for the recent command address table.
package rcat_pkg;

  localparam int CMD_W  = 8;
  localparam int ADDR_W = 16;

  // Item kinds carried on the input tuser bit.
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  code;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic code_hit;
    logic pair_hit;
  } hit_t;

endpackage

// ===== hdl/recent_command_address_table.sv =====
// Top level of the recent command address table: sequencer, write pointer, output register.
//
//   Channel  Dir  Payload                                       Handshake
//   in_*     in   tdata = {reg_addr[23:8], cmd[7:0]}            tvalid/tready
//                 tuser = action (0 record, 1 lookup)
//   out_*    out  tdata = start_addr[15:0], tuser = found       tvalid/tready
//
// Each item scans the table one entry per cycle through a single read port
// and one compare unit, newest entry first. The read data is registered. A
// lookup stops at its first hit and hands its result to the output register
// from a finishing state. A record with no identical pair in the table writes
// it in the cycle that ends the scan. Reset clears the write pointer and
// the per-entry valid bits at once, so no clearing pass is needed. The
// block takes no new item while a scan runs; a stalled output holds a
// finished lookup in its last state until the output register frees up.
module recent_command_address_table import rcat_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] cmd, [23:8] reg_addr
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] start_addr
  output logic [0:0]  out_tuser   // [0] found
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rd_slot_r, rd_slot_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0]  chk_cnt_r, chk_cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic              act_r, act_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              res_found_r, res_found_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic   in_acc;
  logic   rd_en;
  logic   wr_en;
  logic   chk_last;
  entry_t rd_data;
  entry_t wr_data;
  hit_t   hit;

  rcat_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (wp_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (rd_slot_r),
    .rd_data (rd_data)
  );

  rcat_cmp u_cmp (
    .entry    (rd_data),
    .key_code (cmd_r),
    .key_addr (addr_r),
    .hit      (hit)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_en     = (state_r == ST_SCAN) && (iss_cnt_r < CNT_W'(DEPTH));
  assign chk_last  = (chk_cnt_r == CNT_W'(DEPTH - 1));
  assign wr_data   = '{code: cmd_r, addr: addr_r};

  // A record that reaches the end of the scan with no identical pair writes.
  assign wr_en = (state_r == ST_SCAN) && chk_vld_r && (act_r == ACT_RECORD) &&
                 !hit.pair_hit && chk_last;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rd_slot_nxt   = rd_slot_r;
    iss_cnt_nxt   = iss_cnt_r;
    chk_cnt_nxt   = chk_cnt_r;
    chk_vld_nxt   = 1'b0;
    act_nxt       = act_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    res_found_nxt = res_found_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt     = in_tuser[0];
          cmd_nxt     = in_tdata[7:0];
          addr_nxt    = in_tdata[23:8];
          // Newest entry sits just behind the write pointer.
          rd_slot_nxt = (wp_r == '0) ? PTR_W'(DEPTH - 1) : wp_r - 1'b1;
          iss_cnt_nxt = '0;
          chk_cnt_nxt = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_slot_nxt = (rd_slot_r == '0) ? PTR_W'(DEPTH - 1) : rd_slot_r - 1'b1;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
          chk_vld_nxt = 1'b1;
        end
        if (chk_vld_r) begin
          chk_cnt_nxt = chk_cnt_r + 1'b1;
          if (act_r == ACT_LOOKUP) begin
            if (hit.code_hit) begin
              res_found_nxt = 1'b1;
              res_addr_nxt  = rd_data.addr;
              chk_vld_nxt   = 1'b0;
              state_nxt     = ST_DONE;
            end else if (chk_last) begin
              res_found_nxt = 1'b0;
              res_addr_nxt  = '0;
              state_nxt     = ST_DONE;
            end
          end else begin
            if (hit.pair_hit) begin
              chk_vld_nxt = 1'b0;
              state_nxt   = ST_IDLE;
            end else if (chk_last) begin
              wp_nxt    = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_addr_nxt  = res_addr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r   <= rd_slot_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    chk_cnt_r   <= chk_cnt_nxt;
    act_r       <= act_nxt;
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    res_found_r <= res_found_nxt;
    res_addr_r  <= res_addr_nxt;
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_addr_r;
  assign out_tuser[0] = out_found_r;

  // An accepted item always starts a scan.
  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN))
    else $error("accepted item did not start a scan");

  // The write pointer stays inside the table.
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PTR_W'(DEPTH - 1))
    else $error("write pointer out of range");

  // Only a record finishing its scan moves the write pointer.
  a_wp_move: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(wp_r) |-> $past(state_r == ST_SCAN && act_r == ACT_RECORD))
    else $error("write pointer moved outside a record");

  // A result is loaded only from the finishing state of a lookup.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE && act_r == ACT_LOOKUP))
    else $error("result produced without a lookup");

endmodule

// ===== hdl/rcat_store.sv =====
// Entry storage: one write port, one registered read port, per-entry valid bits.
module rcat_store import rcat_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  entry_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  output entry_t                   rd_data
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  entry_t           rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // A slot never written reads as the cleared pair of zeros.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_idx] ? mem[rd_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rcat_cmp.sv =====
// Shared compare unit: matches one read entry against the item's key.
module rcat_cmp import rcat_pkg::*; (
  input  entry_t            entry,
  input  logic [CMD_W-1:0]  key_code,
  input  logic [ADDR_W-1:0] key_addr,
  output hit_t              hit
);

  always_comb begin
    hit.code_hit = (entry.code == key_code);
    hit.pair_hit = (entry.code == key_code) && (entry.addr == key_addr);
  end

endmodule

// ===== bench/rcat_checker.sv =====
// Checker for the recent command address table: mirrors the table and compares lookup answers.
module rcat_checker import rcat_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] cmd, [23:8] reg_addr
  input  logic [0:0]  in_tuser,   // [0] action
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] start_addr
  input  logic [0:0]  out_tuser,  // [0] found
  output int          mismatches,
  output int          lookups_open
);

  localparam int SHOWN_MAX = 10;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] start_addr;
  } answer_t;

  logic [CMD_W-1:0]  mirror_code [DEPTH];
  logic [ADDR_W-1:0] mirror_addr [DEPTH];
  int unsigned       next_slot;
  answer_t           awaited_answers [$];

  // Newest-first search of the mirrored table for a command code.
  function automatic answer_t newest_match(logic [CMD_W-1:0] code);
    answer_t     ans;
    int unsigned slot;
    ans = '0;
    for (int k = 0; k < DEPTH; k++) begin
      slot = (next_slot + DEPTH - 1 - k) % DEPTH;
      if (mirror_code[slot] == code) begin
        ans.found      = 1'b1;
        ans.start_addr = mirror_addr[slot];
        return ans;
      end
    end
    return ans;
  endfunction

  // A pair already held anywhere, cleared slots included, leaves the table alone.
  function automatic void store_pair(logic [CMD_W-1:0] code, logic [ADDR_W-1:0] addr);
    for (int k = 0; k < DEPTH; k++) begin
      if (mirror_code[k] == code && mirror_addr[k] == addr) return;
    end
    mirror_code[next_slot] = code;
    mirror_addr[next_slot] = addr;
    next_slot = (next_slot + 1) % DEPTH;
  endfunction

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        mirror_code[k] = '0;
        mirror_addr[k] = '0;
      end
      next_slot = 0;
      awaited_answers.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.found      = out_tuser[0];
        got.start_addr = out_tdata;
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("%0t: unexpected answer found=%0b start_addr=%h",
                     $realtime, got.found, got.start_addr);
        end else begin
          want = awaited_answers.pop_front();
          if (got.found !== want.found || got.start_addr !== want.start_addr) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
              $display("%0t: answer mismatch: expected found=%0b start_addr=%h, got found=%0b start_addr=%h",
                       $realtime, want.found, want.start_addr, got.found, got.start_addr);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == ACT_LOOKUP)
          awaited_answers.push_back(newest_match(in_tdata[CMD_W-1:0]));
        else
          store_pair(in_tdata[CMD_W-1:0], in_tdata[CMD_W +: ADDR_W]);
      end
    end
    lookups_open = awaited_answers.size();
  end

endmodule

// ===== bench/recent_command_address_table_tb.sv =====
// Testbench top for the recent command address table: stimulus, flow control and verdict.
module recent_command_address_table_tb;
  import rcat_pkg::*;

  localparam int DEPTH        = 8;
  localparam int RANDOM_ITEMS = 1280;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  int fail_count;
  int open_count;

  // Idle chances in percent for the two sides, changed between phases.
  int send_idle = 0;
  int recv_idle = 0;

  // The long receiver hold-off is requested by the stimulus and timed by its own process.
  logic hold_go  = 1'b0;
  logic out_hold = 1'b0;

  int cycle_count = 0;

  recent_command_address_table #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rcat_checker #(.DEPTH(DEPTH)) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .mismatches   (fail_count),
    .lookups_open (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost answer ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver side. It drops tready at random, or solidly while a long hold-off runs.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold)
        out_tready <= 1'b0;
      else
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Long hold-off, counted on rising edges so the receiver process sees a settled flag.
  initial begin
    wait (hold_go);
    @(posedge clk);
    out_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    out_hold = 1'b0;
  end

  // Offers one item from a falling edge and returns at the falling edge after it was taken.
  // Random gaps come first; tvalid stays high when the next item follows straight on.
  task automatic send_item(logic act, logic [CMD_W-1:0] code, logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {addr, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering items until every lookup answer has come out.
  task automatic drain_answers();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (open_count != 0) @(negedge clk);
  endtask

  // Random item. Codes and addresses mostly come from narrow pools so that lookups hit,
  // records repeat stored pairs, and the zero pair of cleared slots keeps turning up.
  // The rest are full-range values so that every bit takes both values.
  task automatic random_item();
    logic              act;
    logic [CMD_W-1:0]  code;
    logic [ADDR_W-1:0] addr;
    int                pick;
    act  = ($urandom_range(0, 1) == 1) ? ACT_LOOKUP : ACT_RECORD;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      code = CMD_W'($urandom_range(0, 9));
    else if (pick < 70)
      code = 8'hF8 | CMD_W'($urandom_range(0, 7));
    else
      code = CMD_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60)
      addr = ADDR_W'($urandom_range(0, 3));
    else if (pick < 70)
      addr = {ADDR_W'($urandom_range(0, 3))} << 14;
    else
      addr = ADDR_W'($urandom);
    send_item(act, code, addr);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_RECORD;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Cleared slots hold code 0 and address 0, so a lookup of code 0
    // answers address 0 and a record of the zero pair is a duplicate at first.
    send_item(ACT_LOOKUP, 8'h00, 16'hFFFF);
    send_item(ACT_LOOKUP, 8'hFF, 16'h0000);
    send_item(ACT_RECORD, 8'h00, 16'h0000);
    send_item(ACT_RECORD, 8'hFF, 16'hFFFF);
    send_item(ACT_LOOKUP, 8'hFF, 16'h1234);
    send_item(ACT_RECORD, 8'hFF, 16'hFFFF);
    // Same code twice: the lookup must return the newer address.
    send_item(ACT_RECORD, 8'h12, 16'h0000);
    send_item(ACT_RECORD, 8'h12, 16'h0001);
    send_item(ACT_LOOKUP, 8'h12, 16'h0000);
    send_item(ACT_RECORD, 8'h00, 16'h8000);
    send_item(ACT_LOOKUP, 8'h00, 16'h0000);
    // Enough fresh pairs to wrap the write pointer and evict the oldest entries.
    for (int k = 0; k < 6; k++)
      send_item(ACT_RECORD, 8'h80 + CMD_W'(k), 16'h5A5A ^ ADDR_W'(k));
    send_item(ACT_LOOKUP, 8'hFF, 16'h0000);
    send_item(ACT_LOOKUP, 8'h12, 16'h0000);
    // No cleared slot is left now, so the zero pair gets written.
    send_item(ACT_RECORD, 8'h00, 16'h0000);
    send_item(ACT_LOOKUP, 8'h00, 16'h0000);
    send_item(ACT_LOOKUP, 8'hAB, 16'hFFFF);
    drain_answers();

    // Random part, phase one: sender rarely idle, receiver often stalls.
    send_idle = 12;
    recv_idle = 59;
    for (int n = 0; n < RANDOM_ITEMS / 3; n++)
      random_item();

    // The sender waits here until every answer so far has come out.
    drain_answers();

    // Phase two: the roles swap.
    send_idle = 59;
    recv_idle = 12;
    for (int n = 0; n < RANDOM_ITEMS / 3; n++)
      random_item();

    // Phase three: neither side idles. Early on the receiver holds off for a long
    // stretch while items keep coming, so the block fills and holds off its input.
    send_idle = 0;
    recv_idle = 0;
    hold_go   = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); n++)
      random_item();

    in_tvalid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    // A final wait catches any stray answer.
    repeat (4 * DEPTH + 8) @(negedge clk);

    if (fail_count == 0 && open_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rcat_pkg.sv
hdl/rcat_store.sv
hdl/rcat_cmp.sv
hdl/recent_command_address_table.sv
bench/rcat_checker.sv
bench/recent_command_address_table_tb.sv
